/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion helpers shared by the small set table modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sst_pkg.sv */
// ----------------------------------------------------------------------------
// sst_pkg
// types and codes shared by the small set table controller, datapath and top
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    // command codes
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_ERASE  = 3'd1;
    localparam logic [2:0] CMD_LOOKUP = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BADPOS  = 3'd4;

    // memory read address source
    typedef enum logic [1:0] {
        ADDR_IDX  = 2'd0,
        ADDR_NEXT = 2'd1,
        ADDR_POS  = 2'd2
    } t_addr_sel;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] key;
        logic [3:0]  position;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [3:0]  where;
        logic [31:0] read_data;
        logic [4:0]  count;
        logic [2:0]  status;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      rd_en;
        t_addr_sel addr_sel;
        logic      idx_inc;
        logic      set_hit;
        logic      wr_shift;
        logic      wr_add;
        logic      held_dec;
        logic      held_clr;
        logic      status_we;
        logic [2:0] status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       idx_lt_held;
        logic       next_lt_held;
        logic       key_eq;
        logic       full;
        logic       pos_ok;
    } t_dp_sts;

endpackage

`default_nettype wire

/* hdl/sst_dp.sv */
// ----------------------------------------------------------------------------
// sst_dp
// entry memory, held count, scan index and result fields of the set table
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sst_dp #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sst_pkg::t_in     i_in,
    input  wire sst_pkg::t_dp_cmd i_cmd,
    output sst_pkg::t_dp_sts      o_sts,
    output sst_pkg::t_out         o_result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 4) ? CW : 4;
    localparam logic [CW-1:0] HELD_FULL = CW'(CAPACITY);

    logic [KEY_WIDTH-1:0] r_mem [CAPACITY];

    logic [2:0]           r_cmd;
    logic [KEY_WIDTH-1:0] r_key;
    logic [3:0]           r_pos;
    logic [CW-1:0]        r_idx;
    logic [IW-1:0]        r_at;
    logic                 r_hit;
    logic [2:0]           r_status;
    logic [CW-1:0]        r_held;
    logic [KEY_WIDTH-1:0] r_rd_data;

    logic [KEY_WIDTH+31:0] key_pad;
    logic [CW:0]           idx_next;
    logic [PW+3:0]         pos_pad;
    logic [PW+CW-1:0]      held_pad;
    logic [IW+3:0]         at_pad;
    logic [KEY_WIDTH+31:0] rd_pad;
    logic [CW+4:0]         cnt_pad;
    logic [IW-1:0]         rd_addr;

    // key zero-extended or cut to the stored width
    assign key_pad  = {{KEY_WIDTH{1'b0}}, i_in.key};
    assign idx_next = {1'b0, r_idx} + {{CW{1'b0}}, 1'b1};
    assign pos_pad  = {{PW{1'b0}}, r_pos};
    assign held_pad = {{PW{1'b0}}, r_held};

    always_comb begin
        case (i_cmd.addr_sel)
            sst_pkg::ADDR_IDX:  rd_addr = r_idx[IW-1:0];
            sst_pkg::ADDR_NEXT: rd_addr = idx_next[IW-1:0];
            sst_pkg::ADDR_POS:  rd_addr = pos_pad[IW-1:0];
            default:            rd_addr = r_idx[IW-1:0];
        endcase
    end

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            r_mem[r_held[IW-1:0]] <= r_key;
        end else if (i_cmd.wr_shift) begin
            r_mem[r_idx[IW-1:0]] <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // captured command item and scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_in.cmd;
            r_key    <= key_pad[KEY_WIDTH-1:0];
            r_pos    <= i_in.position;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_at     <= '0;
            r_status <= sst_pkg::ST_OK;
        end else begin
            if (i_cmd.idx_inc) begin
                r_idx <= idx_next[CW-1:0];
            end
            if (i_cmd.set_hit) begin
                r_hit <= 1'b1;
                r_at  <= r_idx[IW-1:0];
            end
            if (i_cmd.status_we) begin
                r_status <= i_cmd.status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.held_clr) begin
            r_held <= '0;
        end else if (i_cmd.wr_add) begin
            r_held <= r_held + 1'b1;
        end else if (i_cmd.held_dec) begin
            r_held <= r_held - 1'b1;
        end
    end

    assign o_sts.cmd          = r_cmd;
    assign o_sts.idx_lt_held  = (r_idx < r_held);
    assign o_sts.next_lt_held = (idx_next < {1'b0, r_held});
    assign o_sts.key_eq       = (r_rd_data == r_key);
    assign o_sts.full         = (r_held == HELD_FULL);
    assign o_sts.pos_ok       = (pos_pad[PW-1:0] < held_pad[PW-1:0]);

    assign at_pad  = {4'd0, r_at};
    assign rd_pad  = {32'd0, r_rd_data};
    assign cnt_pad = {5'd0, r_held};

    assign o_result.found     = r_hit;
    assign o_result.where     = r_hit ? at_pad[3:0] : 4'd0;
    assign o_result.read_data = ((r_cmd == sst_pkg::CMD_READ) && (r_status == sst_pkg::ST_OK))
                                ? rd_pad[31:0] : 32'd0;
    assign o_result.count     = cnt_pad[4:0];
    assign o_result.status    = r_status;

    `ASSERT_ALWAYS(a_held_range, i_clk, i_rst_n, r_held <= HELD_FULL, "held count past capacity")
    `ASSERT_IMPLY(a_add_room, i_clk, i_rst_n, i_cmd.wr_add, r_held != HELD_FULL, "append to full table")

endmodule

`default_nettype wire

/* hdl/sst_ctrl.sv */
// ----------------------------------------------------------------------------
// sst_ctrl
// command sequencer: scan, append, shift-down erase, clear, positional read
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sst_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_free,
    input  wire sst_pkg::t_dp_sts i_sts,
    output sst_pkg::t_dp_cmd      o_cmd,
    output logic                  o_in_stall,
    output logic                  o_out_load
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_SH_RD = 7'b0001000,
        S_SH_WR = 7'b0010000,
        S_EXEC  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.addr_sel   = sst_pkg::ADDR_IDX;
        o_out_load       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // key-based commands scan; the rest run in exec
                if ((i_sts.cmd != sst_pkg::CMD_ADD) && (i_sts.cmd != sst_pkg::CMD_ERASE) &&
                    (i_sts.cmd != sst_pkg::CMD_LOOKUP)) begin
                    n_state = S_EXEC;
                end else if (i_sts.idx_lt_held) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CMP;
                end else begin
                    o_cmd.status_we = 1'b1;
                    n_state         = S_FIN;
                    if (i_sts.cmd != sst_pkg::CMD_ADD) begin
                        o_cmd.status = sst_pkg::ST_MISSING;
                    end else if (i_sts.full) begin
                        o_cmd.status = sst_pkg::ST_FULL;
                    end else begin
                        o_cmd.status = sst_pkg::ST_OK;
                        o_cmd.wr_add = 1'b1;
                    end
                end
            end
            S_CMP: begin
                if (i_sts.key_eq) begin
                    o_cmd.set_hit = 1'b1;
                    if (i_sts.cmd == sst_pkg::CMD_ERASE) begin
                        n_state = S_SH_RD;
                    end else begin
                        if (i_sts.cmd == sst_pkg::CMD_ADD) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = sst_pkg::ST_DUP;
                        end
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SH_RD: begin
                if (i_sts.next_lt_held) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = sst_pkg::ADDR_NEXT;
                    n_state        = S_SH_WR;
                end else begin
                    o_cmd.held_dec = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SH_RD;
            end
            S_EXEC: begin
                if (i_sts.cmd == sst_pkg::CMD_READ) begin
                    if (i_sts.pos_ok) begin
                        o_cmd.rd_en    = 1'b1;
                        o_cmd.addr_sel = sst_pkg::ADDR_POS;
                    end else begin
                        o_cmd.status_we = 1'b1;
                        o_cmd.status    = sst_pkg::ST_BADPOS;
                    end
                end else if (i_sts.cmd == sst_pkg::CMD_CLEAR) begin
                    o_cmd.held_clr = 1'b1;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state == S_SCAN, "accept did not start work")
    `ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, o_out_load, i_out_free, "result loaded over pending one")
    `ASSERT_IMPLY(a_one_write, i_clk, i_rst_n, o_cmd.wr_add, !o_cmd.wr_shift, "two memory writes at once")

endmodule

`default_nettype wire

/* hdl/small_set_table.sv */
// ----------------------------------------------------------------------------
// small_set_table
// set of distinct keys in a packed table: add, erase, lookup, read, clear
// ----------------------------------------------------------------------------
//
//  channel   valid        stall        payload
//  -------   ----------   ----------   -----------------------------------
//  command   i_in_valid   o_in_stall   i_in_data  (cmd, key, position)
//  result    o_out_valid  i_out_stall  o_out_data (found, where, read_data,
//                                                  count, status)
//
//  one command at a time, one result transfer per command transfer
//  add / lookup: each entry scanned takes a memory read, then a compare, until a hit or a miss
//  is found; erase: scan and shift-down together touch every entry
//  read, clear and unused codes skip the scan and go straight to exec
//  scan and shift steps all go through the single registered read port of the entry memory
//  reset clears the held count and the sequencer; entries stay undefined
//  a stalled result sits in the output register while the next command runs
//
`default_nettype none

module small_set_table #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire sst_pkg::t_in i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output sst_pkg::t_out     o_out_data,
    input  wire logic         i_out_stall
);

    sst_pkg::t_dp_cmd dp_cmd;
    sst_pkg::t_dp_sts dp_sts;
    sst_pkg::t_out    result;
    logic             out_load;
    logic             out_free;

    logic             r_out_valid;
    sst_pkg::t_out    r_out;

    // output register can take a new result when empty or draining now
    assign out_free = !r_out_valid || !i_out_stall;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall),
        .o_out_load (out_load)
    );

    sst_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in_data),
        .i_cmd    (dp_cmd),
        .o_sts    (dp_sts),
        .o_result (result)
    );

    // result register, parts the result side from the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* tb/small_set_table_tb.sv */
// ----------------------------------------------------------------------------
// small_set_table_tb
// self-checking testbench for the small set table: a short table of directed
// commands, then random command mixes that grow, churn and drain the set; every
// result transfer is compared field by field against a typed-in result or a local model of the set
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module small_set_table_tb;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 1675;
    localparam int MAX_WAIT     = 6;
    // longest command is an erase in a full table
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT_CYCLES = 700000;

    // command codes the block answers without doing anything
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // random command mix, switched every few dozen commands
    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_CHURN,
        MIX_SHRINK
    } t_mix;

    // one directed command, with its result typed in where it is obvious
    typedef struct {
        sst_pkg::t_in  stim;
        bit            typed;
        sst_pkg::t_out want;
    } t_plan_row;

    logic           i_clk;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    sst_pkg::t_in   i_in_data   = '0;
    logic           o_in_stall;
    logic           o_out_valid;
    sst_pkg::t_out  o_out_data;
    logic           i_out_stall = 1'b0;

    // local copy of the set: packed keys in insertion order plus the count
    logic [31:0] set_keys [SLOTS];
    int unsigned set_held = 0;

    // results still owed by the block, oldest first
    sst_pkg::t_out awaited_replies [$];
    t_plan_row     directed_plan [$];

    // keys recently used, so erase and lookup often hit or just miss
    logic [31:0] recent_keys [8];
    int          recent_wr = 0;

    t_mix          mix = MIX_GROW;
    bit            calm = 1'b0;      // no gaps and no stalls while set
    int            stall_left = 0;
    int            cycle_count = 0;
    int            errors = 0;
    int            results_seen = 0;
    int            cmd_seen [8];
    int            fills = 0;
    int            full_refusals = 0;
    int            duplicates = 0;
    sst_pkg::t_out oldest_reply;
    int            sink_hold;

    small_set_table #(
        .CAPACITY  (SLOTS),
        .KEY_WIDTH (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // cycles a side waits before its next transfer
    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // applies one command to the local set and returns the result it must give
    function automatic sst_pkg::t_out apply_command(input sst_pkg::t_in c);
        sst_pkg::t_out r;
        int            hit_at;
        int unsigned   i;
        r      = '0;
        hit_at = -1;
        // linear search over the held part only
        for (i = 0; i < set_held; i++) begin
            if (hit_at < 0 && set_keys[i] == c.key) begin
                hit_at = i;
            end
        end
        case (c.cmd)
            sst_pkg::CMD_ADD: begin
                if (hit_at >= 0) begin
                    r.found  = 1'b1;
                    r.where  = hit_at[3:0];
                    r.status = sst_pkg::ST_DUP;
                    duplicates++;
                end else if (set_held >= SLOTS) begin
                    r.status = sst_pkg::ST_FULL;
                    full_refusals++;
                end else begin
                    set_keys[set_held] = c.key;
                    set_held++;
                    if (set_held == SLOTS) begin
                        fills++;
                    end
                end
            end
            sst_pkg::CMD_ERASE: begin
                if (hit_at >= 0) begin
                    r.found = 1'b1;
                    r.where = hit_at[3:0];
                    // close the gap: later entries move down one place
                    for (i = hit_at; i + 1 < set_held; i++) begin
                        set_keys[i] = set_keys[i + 1];
                    end
                    set_held--;
                end else begin
                    r.status = sst_pkg::ST_MISSING;
                end
            end
            sst_pkg::CMD_LOOKUP: begin
                if (hit_at >= 0) begin
                    r.found = 1'b1;
                    r.where = hit_at[3:0];
                end else begin
                    r.status = sst_pkg::ST_MISSING;
                end
            end
            sst_pkg::CMD_READ: begin
                if (c.position < set_held) begin
                    r.read_data = set_keys[c.position];
                end else begin
                    r.status = sst_pkg::ST_BADPOS;
                end
            end
            sst_pkg::CMD_CLEAR: begin
                // entries keep their bits, only the count goes
                set_held = 0;
            end
            default: begin
            end
        endcase
        r.count = set_held[4:0];
        return r;
    endfunction

    function automatic t_plan_row plan_row(input logic [2:0] cmd, input logic [31:0] key,
                                           input logic [3:0] pos, input bit typed,
                                           input logic found, input logic [3:0] at,
                                           input logic [31:0] data, input logic [4:0] count,
                                           input logic [2:0] status);
        t_plan_row r;
        r.stim.cmd       = cmd;
        r.stim.key       = key;
        r.stim.position  = pos;
        r.typed          = typed;
        r.want.found     = found;
        r.want.where     = at;
        r.want.read_data = data;
        r.want.count     = count;
        r.want.status    = status;
        return r;
    endfunction

    // random command, drawn by the current mix, with keys biased toward ones that are held
    function automatic sst_pkg::t_in pick_command();
        sst_pkg::t_in c;
        int           roll;
        int           cut_add, cut_erase, cut_lookup, cut_read, cut_clear;
        roll       = $urandom_range(0, 99);
        c.key      = $urandom;
        c.position = $urandom_range(0, 15);
        case (mix)
            MIX_GROW:  begin
                cut_add = 70; cut_erase = 75; cut_lookup = 85; cut_read = 95; cut_clear = 96;
            end
            MIX_CHURN: begin
                cut_add = 35; cut_erase = 60; cut_lookup = 75; cut_read = 95; cut_clear = 97;
            end
            default:   begin
                cut_add = 10; cut_erase = 60; cut_lookup = 75; cut_read = 95; cut_clear = 97;
            end
        endcase
        if (roll < cut_add) begin
            c.cmd = sst_pkg::CMD_ADD;
        end else if (roll < cut_erase) begin
            c.cmd = sst_pkg::CMD_ERASE;
        end else if (roll < cut_lookup) begin
            c.cmd = sst_pkg::CMD_LOOKUP;
        end else if (roll < cut_read) begin
            c.cmd = sst_pkg::CMD_READ;
        end else if (roll < cut_clear) begin
            c.cmd = sst_pkg::CMD_CLEAR;
        end else begin
            case ($urandom_range(0, 2))
                0:       c.cmd = CMD_SPARE_5;
                1:       c.cmd = CMD_SPARE_6;
                default: c.cmd = CMD_SPARE_7;
            endcase
        end

        if (c.cmd == sst_pkg::CMD_ADD || c.cmd == sst_pkg::CMD_ERASE ||
            c.cmd == sst_pkg::CMD_LOOKUP) begin
            roll = $urandom_range(0, 99);
            if (roll < 45 && set_held > 0) begin
                c.key = set_keys[$urandom_range(0, set_held - 1)];
            end else if (roll < 65) begin
                c.key = recent_keys[$urandom_range(0, 7)];
            end else if (roll < 72) begin
                c.key = $urandom_range(0, 3);
            end
            recent_keys[recent_wr] = c.key;
            recent_wr = (recent_wr + 1) % 8;
        end
        // reads mostly land inside the held part, the rest anywhere
        if (c.cmd == sst_pkg::CMD_READ && set_held > 0 && $urandom_range(0, 3) != 0) begin
            c.position = $urandom_range(0, set_held - 1);
        end
        return c;
    endfunction

    // one command transfer; valid stays high across back-to-back transfers
    task automatic send_command(input sst_pkg::t_in c, input bit typed,
                                input sst_pkg::t_out want);
        int            gap;
        sst_pkg::t_out predicted;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        do @(posedge i_clk); while (o_in_stall);
        // transfer taken at this edge
        predicted = apply_command(c);
        awaited_replies.push_back(typed ? want : predicted);
        cmd_seen[c.cmd]++;
    endtask

    task automatic report(input string msg);
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        errors++;
    endtask

    task automatic compare_reply(input sst_pkg::t_out got, input sst_pkg::t_out want);
        if (got.found !== want.found)
            report($sformatf("found %b, want %b", got.found, want.found));
        if (got.where !== want.where)
            report($sformatf("where %0d, want %0d", got.where, want.where));
        if (got.read_data !== want.read_data)
            report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
        if (got.count !== want.count)
            report($sformatf("count %0d, want %0d", got.count, want.count));
        if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask

    // result side: check each transfer, then stall for a drawn number of cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (awaited_replies.size() == 0) begin
                    report("result transfer with no command outstanding");
                end else begin
                    oldest_reply = awaited_replies.pop_front();
                    compare_reply(o_out_data, oldest_reply);
                end
                sink_hold = draw_wait();
                if (sink_hold > 0) begin
                    i_out_stall <= 1'b1;
                    stall_left  <= sink_hold;
                end
            end else if (stall_left > 1) begin
                stall_left <= stall_left - 1;
            end else if (stall_left == 1) begin
                stall_left  <= 0;
                i_out_stall <= 1'b0;
            end
        end
    end

    // run limit, far above the slowest legal run
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, awaited_replies.size());
        $display("small_set_table regression: fail");
        $finish;
    end

    initial begin
        int n;
        foreach (cmd_seen[k]) cmd_seen[k] = 0;
        foreach (recent_keys[k]) recent_keys[k] = '0;
        foreach (set_keys[k]) set_keys[k] = '0;

        // empty set: every miss case and a spare code
        directed_plan.push_back(plan_row(sst_pkg::CMD_READ, 32'h0, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd0, sst_pkg::ST_BADPOS));
        directed_plan.push_back(plan_row(sst_pkg::CMD_LOOKUP, 32'h0, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd0, sst_pkg::ST_MISSING));
        directed_plan.push_back(plan_row(sst_pkg::CMD_ERASE, 32'hffffffff, 4'd15, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd0, sst_pkg::ST_MISSING));
        directed_plan.push_back(plan_row(CMD_SPARE_5, 32'h0, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd0, sst_pkg::ST_OK));
        // extreme keys, then duplicates of both
        directed_plan.push_back(plan_row(sst_pkg::CMD_ADD, 32'h0, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd1, sst_pkg::ST_OK));
        directed_plan.push_back(plan_row(sst_pkg::CMD_ADD, 32'hffffffff, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd2, sst_pkg::ST_OK));
        directed_plan.push_back(plan_row(sst_pkg::CMD_ADD, 32'h0, 4'd0, 1'b1,
                                1'b1, 4'd0, 32'h0, 5'd2, sst_pkg::ST_DUP));
        directed_plan.push_back(plan_row(sst_pkg::CMD_ADD, 32'hffffffff, 4'd0, 1'b1,
                                1'b1, 4'd1, 32'h0, 5'd2, sst_pkg::ST_DUP));
        directed_plan.push_back(plan_row(sst_pkg::CMD_LOOKUP, 32'hffffffff, 4'd0, 1'b1,
                                1'b1, 4'd1, 32'h0, 5'd2, sst_pkg::ST_OK));
        directed_plan.push_back(plan_row(sst_pkg::CMD_READ, 32'h0, 4'd1, 1'b1,
                                1'b0, 4'd0, 32'hffffffff, 5'd2, sst_pkg::ST_OK));
        // reads just past the end and at the top position
        directed_plan.push_back(plan_row(sst_pkg::CMD_READ, 32'h0, 4'd2, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd2, sst_pkg::ST_BADPOS));
        directed_plan.push_back(plan_row(sst_pkg::CMD_READ, 32'h0, 4'd15, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd2, sst_pkg::ST_BADPOS));
        directed_plan.push_back(plan_row(sst_pkg::CMD_ADD, 32'ha5a5a5a5, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd3, sst_pkg::ST_OK));
        directed_plan.push_back(plan_row(sst_pkg::CMD_ADD, 32'h5a5a5a5a, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd4, sst_pkg::ST_OK));
        // erase at the front shifts the rest down; checked against the model
        directed_plan.push_back(plan_row(sst_pkg::CMD_ERASE, 32'h0, 4'd0, 1'b0,
                                1'b0, 4'd0, 32'h0, 5'd0, sst_pkg::ST_OK));
        directed_plan.push_back(plan_row(sst_pkg::CMD_READ, 32'h0, 4'd0, 1'b0,
                                1'b0, 4'd0, 32'h0, 5'd0, sst_pkg::ST_OK));
        directed_plan.push_back(plan_row(sst_pkg::CMD_READ, 32'h0, 4'd2, 1'b0,
                                1'b0, 4'd0, 32'h0, 5'd0, sst_pkg::ST_OK));
        // erase of the last entry, then it is gone
        directed_plan.push_back(plan_row(sst_pkg::CMD_ERASE, 32'h5a5a5a5a, 4'd0, 1'b1,
                                1'b1, 4'd2, 32'h0, 5'd2, sst_pkg::ST_OK));
        directed_plan.push_back(plan_row(sst_pkg::CMD_LOOKUP, 32'h5a5a5a5a, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd2, sst_pkg::ST_MISSING));
        directed_plan.push_back(plan_row(CMD_SPARE_7, 32'h0, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd2, sst_pkg::ST_OK));
        directed_plan.push_back(plan_row(CMD_SPARE_6, 32'hffffffff, 4'd15, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd2, sst_pkg::ST_OK));
        // clear keeps the bits but nothing is reachable afterwards
        directed_plan.push_back(plan_row(sst_pkg::CMD_CLEAR, 32'hffffffff, 4'd15, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd0, sst_pkg::ST_OK));
        directed_plan.push_back(plan_row(sst_pkg::CMD_READ, 32'h0, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd0, sst_pkg::ST_BADPOS));
        directed_plan.push_back(plan_row(sst_pkg::CMD_LOOKUP, 32'hffffffff, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd0, sst_pkg::ST_MISSING));
        directed_plan.push_back(plan_row(sst_pkg::CMD_ADD, 32'ha5a5a5a5, 4'd0, 1'b1,
                                1'b0, 4'd0, 32'h0, 5'd1, sst_pkg::ST_OK));

        // synchronous reset, released once and never again
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[k]) begin
            send_command(directed_plan[k].stim, directed_plan[k].typed, directed_plan[k].want);
        end

        // random part: the first mix is growth so the table fills early on
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                calm = (n != 0) && ($urandom_range(0, 3) == 0);
            end
            if (n % 60 == 0 && n != 0) begin
                case ($urandom_range(0, 2))
                    0:       mix = MIX_GROW;
                    1:       mix = MIX_CHURN;
                    default: mix = MIX_SHRINK;
                endcase
            end
            send_command(pick_command(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // drain: every result in, then a quiet stretch to catch strays
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("commands: add %0d, erase %0d, lookup %0d, read %0d, clear %0d, spare %0d",
                 cmd_seen[sst_pkg::CMD_ADD], cmd_seen[sst_pkg::CMD_ERASE],
                 cmd_seen[sst_pkg::CMD_LOOKUP], cmd_seen[sst_pkg::CMD_READ],
                 cmd_seen[sst_pkg::CMD_CLEAR],
                 cmd_seen[CMD_SPARE_5] + cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7]);
        $display("%0d results checked; table filled %0d times, %0d adds refused full, %0d dups",
                 results_seen, fills, full_refusals, duplicates);
        if (errors == 0) begin
            $display("small_set_table regression: pass");
        end else begin
            $display("small_set_table regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/sst_pkg.sv
hdl/sst_dp.sv
hdl/sst_ctrl.sv
hdl/small_set_table.sv
tb/small_set_table_tb.sv
